>>> sv/sks_pkg.sv
// Shared types and constants for the servo keyframe stepper.
// Holds the transfer structs, lane control struct and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package sks_pkg;

  localparam int NUM_JOINTS    = 8;
  localparam int ANGLE_MAX     = 180;
  localparam int IO_JOINTS     = 8;
  localparam int ACTIVE_JOINTS = (NUM_JOINTS < IO_JOINTS) ? NUM_JOINTS : IO_JOINTS;
  localparam int REST_ANGLE    = (ANGLE_MAX < 90) ? ANGLE_MAX : 90;

  localparam int ANGLE_W    = 8;
  localparam int OFFSET_W   = 7;
  localparam int SUM_W      = ANGLE_W + 2;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int IDX_W      = $clog2(IO_JOINTS);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [ANGLE_W-1:0] target0;
    logic [ANGLE_W-1:0] target1;
    logic [ANGLE_W-1:0] target2;
    logic [ANGLE_W-1:0] target3;
    logic [ANGLE_W-1:0] target4;
    logic [ANGLE_W-1:0] target5;
    logic [ANGLE_W-1:0] target6;
    logic [ANGLE_W-1:0] target7;
    logic [7:0]         dwell_in;
    logic               final_row;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle0;
    logic [ANGLE_W-1:0] angle1;
    logic [ANGLE_W-1:0] angle2;
    logic [ANGLE_W-1:0] angle3;
    logic [ANGLE_W-1:0] angle4;
    logic [ANGLE_W-1:0] angle5;
    logic [ANGLE_W-1:0] angle6;
    logic [ANGLE_W-1:0] angle7;
    logic [7:0]         moved_mask;
    logic [7:0]         dwell_out;
    logic               row_reached;
    logic               sequence_done;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

endpackage

>>> sv/sks_cfg_regs.sv
// APB-style register file holding the eight signed calibration offsets.
// Depends on sks_pkg.
`timescale 1ns / 1ps

module sks_cfg_regs import sks_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  output logic signed [OFFSET_W-1:0]   offset [IO_JOINTS]
);

  logic [IDX_W-1:0] idx;

  assign idx    = paddr[IDX_W+1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < IO_JOINTS; j++) begin
        offset[j] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      offset[idx] <= pwdata[OFFSET_W-1:0];
    end
  end

  assign prdata = {{(CFG_DATA_W-OFFSET_W){offset[idx][OFFSET_W-1]}}, offset[idx]};

endmodule

>>> sv/sks_lane.sv
// One joint lane: saturated target latch, current angle and unit step logic.
// Depends on sks_pkg.
`timescale 1ns / 1ps

module sks_lane import sks_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctl_t                  ctl,
  input  logic [ANGLE_W-1:0]         target_in,
  input  logic signed [OFFSET_W-1:0] offset,
  output logic [ANGLE_W-1:0]         angle_next,
  output logic                       moved,
  output logic                       reached
);

  logic [ANGLE_W-1:0]      angle;
  logic [ANGLE_W-1:0]      target;
  logic [ANGLE_W-1:0]      target_next;
  logic signed [SUM_W-1:0] sum;

  assign sum = $signed({2'b00, target_in}) + SUM_W'(offset);

  always_comb begin
    if (sum[SUM_W-1]) begin
      target_next = '0;
    end else if (sum > $signed(SUM_W'(ANGLE_MAX))) begin
      target_next = ANGLE_W'(ANGLE_MAX);
    end else begin
      target_next = sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    angle_next = angle;
    moved      = 1'b0;
    if (ctl.step) begin
      if (angle < target) begin
        angle_next = angle + 1'b1;
        moved      = 1'b1;
      end else if (angle > target) begin
        angle_next = angle - 1'b1;
        moved      = 1'b1;
      end
    end
  end

  assign reached = (angle_next == target);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle  <= ANGLE_W'(REST_ANGLE);
      target <= ANGLE_W'(REST_ANGLE);
    end else begin
      if (ctl.step) begin
        angle <= angle_next;
      end
      if (ctl.load) begin
        target <= target_next;
      end
    end
  end

endmodule

>>> sv/sks_out_reg.sv
// Result register with valid/ready handshake; it takes a new result whenever
// it is empty or its current result is being transferred. Depends on sks_pkg.
`timescale 1ns / 1ps

module sks_out_reg import sks_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t item_next,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  assign space = !rst && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

>>> sv/servo_keyframe_stepper.sv
// Top level of the eight-joint servo keyframe stepper.
// Depends on sks_pkg, sks_cfg_regs, sks_lane and sks_out_reg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | in_item  (in_item_t)
//  output   | out_valid / out_ready| out_item (out_item_t)
//  config   | psel/penable/pready  | paddr, pwdata, prdata
//
// Results appear the cycle after acceptance; a new request can be accepted
// every cycle while the result register is free. The lane compare-and-step
// logic sits between the joint registers and the result register.
// Reset is synchronous; joints and targets return to the rest angle.
// While a result waits on out_ready, in_ready is low and nothing is accepted.
`timescale 1ns / 1ps

module servo_keyframe_stepper import sks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic signed [OFFSET_W-1:0] offset [IO_JOINTS];
  logic [ANGLE_W-1:0]         tgt [IO_JOINTS];
  logic [ANGLE_W-1:0]         ang [IO_JOINTS];
  logic [IO_JOINTS-1:0]       moved;
  logic [IO_JOINTS-1:0]       reached;
  logic                       accept;
  lane_ctl_t                  ctl;
  logic [7:0]                 row_dwell;
  logic                       row_is_final;
  logic                       all_reached;
  out_item_t                  item_next;

  sks_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .offset  (offset)
  );

  assign accept   = in_valid && in_ready;
  assign ctl.load = accept && (in_item.req_type == REQ_LOAD);
  assign ctl.step = accept && (in_item.req_type == REQ_STEP);

  assign tgt[0] = in_item.target0;
  assign tgt[1] = in_item.target1;
  assign tgt[2] = in_item.target2;
  assign tgt[3] = in_item.target3;
  assign tgt[4] = in_item.target4;
  assign tgt[5] = in_item.target5;
  assign tgt[6] = in_item.target6;
  assign tgt[7] = in_item.target7;

  for (genvar j = 0; j < IO_JOINTS; j++) begin : g_lane
    if (j < ACTIVE_JOINTS) begin : g_on
      sks_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .target_in  (tgt[j]),
        .offset     (offset[j]),
        .angle_next (ang[j]),
        .moved      (moved[j]),
        .reached    (reached[j])
      );
    end else begin : g_off
      assign ang[j]     = '0;
      assign moved[j]   = 1'b0;
      assign reached[j] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_dwell    <= '0;
      row_is_final <= 1'b0;
    end else if (ctl.load) begin
      row_dwell    <= in_item.dwell_in;
      row_is_final <= in_item.final_row;
    end
  end

  assign all_reached = &reached;

  always_comb begin
    item_next.angle0        = ang[0];
    item_next.angle1        = ang[1];
    item_next.angle2        = ang[2];
    item_next.angle3        = ang[3];
    item_next.angle4        = ang[4];
    item_next.angle5        = ang[5];
    item_next.angle6        = ang[6];
    item_next.angle7        = ang[7];
    item_next.moved_mask    = ctl.step ? moved : '0;
    item_next.dwell_out     = ctl.step ? row_dwell : '0;
    item_next.row_reached   = ctl.step && all_reached;
    item_next.sequence_done = ctl.step && all_reached && row_is_final;
  end

  sks_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .item_next (item_next),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> sv/sks_checker.sv
// Port-level assertions for the servo keyframe stepper and the bind that
// attaches them to the top level. Depends on sks_pkg and servo_keyframe_stepper.
`timescale 1ns / 1ps

module sks_checker import sks_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow result register space");

  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.sequence_done |-> out_item.row_reached)
    else $error("sequence done without row reached");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.angle0 <= ANGLE_W'(ANGLE_MAX))
               && (out_item.angle7 <= ANGLE_W'(ANGLE_MAX)))
    else $error("angle above the upper limit");

endmodule

bind servo_keyframe_stepper sks_checker u_sks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> dv/tb_servo_keyframe_stepper.sv
// Self-checking testbench for the servo keyframe stepper, with directed and random phases.
// Predicts every result from its own copy of the joint state and checks it on the output side.
// Depends on sks_pkg and the servo_keyframe_stepper top level.
`timescale 1ns / 1ps

module tb_servo_keyframe_stepper;
  import sks_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;

  servo_keyframe_stepper dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  int        joint_deg [IO_JOINTS];
  int        aim_deg   [IO_JOINTS];
  int        trim_deg  [IO_JOINTS];
  int        row_dwell_ms;
  bit        row_last;
  out_item_t expected_passes[$];
  int        error_count;
  int        cycle_count;

  int        tx_burst_left;
  bit        tx_free;
  bit        rx_free;
  int        hold_len;
  int        hold_seq;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void reset_joints();
    for (int j = 0; j < IO_JOINTS; j++) begin
      joint_deg[j] = REST_ANGLE;
      aim_deg[j]   = REST_ANGLE;
      trim_deg[j]  = 0;
    end
    row_dwell_ms = 0;
    row_last     = 1'b0;
  endfunction

  function automatic out_item_t predict_pass(in_item_t it);
    out_item_t r;
    int        tgt [IO_JOINTS];
    int        ang [IO_JOINTS];
    logic [7:0] mask;
    bit        reached;
    tgt = '{it.target0, it.target1, it.target2, it.target3,
            it.target4, it.target5, it.target6, it.target7};
    mask    = '0;
    reached = 1'b1;
    if (it.req_type == REQ_LOAD) begin
      for (int j = 0; j < ACTIVE_JOINTS; j++)
        aim_deg[j] = clamp(tgt[j] + trim_deg[j], 0, ANGLE_MAX);
      row_dwell_ms = it.dwell_in;
      row_last     = it.final_row;
    end else begin
      for (int j = 0; j < ACTIVE_JOINTS; j++) begin
        if (joint_deg[j] < aim_deg[j]) begin
          joint_deg[j]++;
          mask[j] = 1'b1;
        end else if (joint_deg[j] > aim_deg[j]) begin
          joint_deg[j]--;
          mask[j] = 1'b1;
        end
        if (joint_deg[j] != aim_deg[j]) reached = 1'b0;
      end
    end
    for (int j = 0; j < IO_JOINTS; j++)
      ang[j] = (j < ACTIVE_JOINTS) ? joint_deg[j] : 0;
    r.angle0 = 8'(ang[0]);
    r.angle1 = 8'(ang[1]);
    r.angle2 = 8'(ang[2]);
    r.angle3 = 8'(ang[3]);
    r.angle4 = 8'(ang[4]);
    r.angle5 = 8'(ang[5]);
    r.angle6 = 8'(ang[6]);
    r.angle7 = 8'(ang[7]);
    if (it.req_type == REQ_STEP) begin
      r.moved_mask    = mask;
      r.dwell_out     = 8'(row_dwell_ms);
      r.row_reached   = reached;
      r.sequence_done = reached & row_last;
    end else begin
      r.moved_mask    = '0;
      r.dwell_out     = '0;
      r.row_reached   = 1'b0;
      r.sequence_done = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_passes.push_back(predict_pass(in_item));
  end

  always @(posedge clk) begin
    if (!rst && psel && penable && pwrite && pready && (paddr >> 2) < IO_JOINTS)
      trim_deg[paddr >> 2] = int'($signed(pwdata[OFFSET_W-1:0]));
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_passes.size() == 0) begin
        $error("result transfer with no expected result waiting");
        error_count++;
      end else begin
        exp_r = expected_passes.pop_front();
        check_field("angle0", exp_r.angle0, out_item.angle0);
        check_field("angle1", exp_r.angle1, out_item.angle1);
        check_field("angle2", exp_r.angle2, out_item.angle2);
        check_field("angle3", exp_r.angle3, out_item.angle3);
        check_field("angle4", exp_r.angle4, out_item.angle4);
        check_field("angle5", exp_r.angle5, out_item.angle5);
        check_field("angle6", exp_r.angle6, out_item.angle6);
        check_field("angle7", exp_r.angle7, out_item.angle7);
        check_field("moved_mask", exp_r.moved_mask, out_item.moved_mask);
        check_field("dwell_out", exp_r.dwell_out, out_item.dwell_out);
        check_field("row_reached", exp_r.row_reached, out_item.row_reached);
        check_field("sequence_done", exp_r.sequence_done, out_item.sequence_done);
      end
    end
  end

  initial begin
    int seen_seq;
    int stall_left;
    int run_left;
    seen_seq   = 0;
    stall_left = 0;
    run_left   = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq   = hold_seq;
        stall_left = hold_len;
        run_left   = 0;
      end
      if (rx_free && stall_left == 0) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready = 1'b1;
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 10);
        stall_left = $urandom_range(0, 5);
        out_ready  = 1'b1;
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("** servo_keyframe_stepper: FAILED **");
    $finish;
  end

  function automatic in_item_t make_item(logic kind, int tgt [IO_JOINTS], int dwell,
                                         logic fin);
    in_item_t it;
    it.req_type  = kind;
    it.target0   = 8'(tgt[0]);
    it.target1   = 8'(tgt[1]);
    it.target2   = 8'(tgt[2]);
    it.target3   = 8'(tgt[3]);
    it.target4   = 8'(tgt[4]);
    it.target5   = 8'(tgt[5]);
    it.target6   = 8'(tgt[6]);
    it.target7   = 8'(tgt[7]);
    it.dwell_in  = 8'(dwell);
    it.final_row = fin;
    return it;
  endfunction

  // Every task below starts and ends at a falling edge.
  task automatic send_request(in_item_t it);
    int gap;
    if (!tx_free) begin
      if (tx_burst_left == 0) begin
        gap           = $urandom_range(0, 6);
        tx_burst_left = $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      tx_burst_left--;
    end
    in_valid = 1'b1;
    in_item  = it;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic send_load(int tgt [IO_JOINTS], int dwell, logic fin);
    send_request(make_item(REQ_LOAD, tgt, dwell, fin));
  endtask

  task automatic send_step();
    int tgt [IO_JOINTS];
    for (int j = 0; j < IO_JOINTS; j++) tgt[j] = $urandom_range(0, 255);
    send_request(make_item(REQ_STEP, tgt, $urandom_range(0, 255), 1'($urandom)));
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_passes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_offset(int idx, int value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = CFG_ADDR_W'(idx * 4);
    pwdata  = {$urandom} & ~32'h7f | (32'(value) & 32'h7f);
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_offsets(int offs [IO_JOINTS]);
    wait_drained();
    for (int j = 0; j < IO_JOINTS; j++) write_offset(j, offs[j]);
  endtask

  function automatic void near_targets(output int tgt [IO_JOINTS], input int reach);
    int want;
    for (int j = 0; j < IO_JOINTS; j++) begin
      want   = clamp(joint_deg[j] + $urandom_range(0, 2 * reach) - reach, 0, ANGLE_MAX);
      tgt[j] = clamp(want - trim_deg[j], 0, 255);
    end
  endfunction

  task automatic test_rest_step();
    send_step();
    send_step();
  endtask

  task automatic test_load_extremes();
    int hi [IO_JOINTS] = '{default: 255};
    int lo [IO_JOINTS] = '{default: 0};
    send_load(hi, 255, 1'b1);
    send_step();
    send_step();
    send_load(lo, 0, 1'b0);
    send_step();
    send_step();
    send_step();
  endtask

  task automatic test_final_row();
    int tgt [IO_JOINTS];
    near_targets(tgt, 0);
    send_load(tgt, 17, 1'b1);
    send_step();
    send_step();
    tgt[3] = clamp(tgt[3] + 1, 0, 255);
    send_load(tgt, 200, 1'b1);
    send_step();
    send_step();
  endtask

  task automatic test_offset_saturation();
    int offs [IO_JOINTS] = '{-64, 63, -64, 63, -64, 63, 0, -1};
    int tgt  [IO_JOINTS] = '{0, 255, 100, 120, 30, 140, 90, 91};
    int zero [IO_JOINTS] = '{default: 0};
    set_offsets(offs);
    tx_free = 1'b1;
    send_load(tgt, 1, 1'b0);
    send_step();
    send_step();
    tgt = '{255, 0, 255, 0, 64, 117, 0, 255};
    send_load(tgt, 128, 1'b1);
    send_step();
    tx_free = 1'b0;
    set_offsets(zero);
  endtask

  task automatic test_backpressure_fill();
    int tgt [IO_JOINTS];
    tx_free  = 1'b1;
    hold_len = 80;
    hold_seq++;
    near_targets(tgt, 6);
    send_load(tgt, $urandom_range(0, 255), 1'($urandom));
    repeat (30) send_step();
    tx_free = 1'b0;
  endtask

  task automatic test_drained_pause();
    int tgt [IO_JOINTS];
    near_targets(tgt, 3);
    send_load(tgt, $urandom_range(0, 255), 1'b1);
    repeat (3) send_step();
    wait_drained();
    repeat (4) send_step();
  endtask

  task automatic random_rows(int n_items);
    int tgt [IO_JOINTS];
    int sent;
    int steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        near_targets(tgt, $urandom_range(0, 6));
        send_load(tgt, $urandom_range(0, 255), 1'($urandom));
        steps = $urandom_range(1, 9);
      end else begin
        for (int j = 0; j < IO_JOINTS; j++) tgt[j] = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) begin
          send_load(tgt, $urandom_range(0, 255), 1'($urandom));
          steps = $urandom_range(0, 3);
        end else begin
          send_step();
          steps = 0;
        end
      end
      sent++;
      repeat (steps) begin
        send_step();
        sent++;
      end
      if ($urandom_range(0, 15) == 0) begin
        tx_free = ~tx_free;
        rx_free = $urandom_range(0, 1);
      end
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  task automatic test_random_phases();
    int offs [IO_JOINTS];
    for (int p = 0; p < 4; p++) begin
      for (int j = 0; j < IO_JOINTS; j++) begin
        case ($urandom_range(0, 3))
          0: offs[j] = -64;
          1: offs[j] = 63;
          default: offs[j] = $urandom_range(0, 127) - 64;
        endcase
      end
      set_offsets(offs);
      random_rows(115);
    end
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_item       = '0;
    error_count   = 0;
    tx_burst_left = 0;
    tx_free       = 1'b0;
    rx_free       = 1'b0;
    hold_len      = 0;
    hold_seq      = 0;
    reset_joints();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_rest_step();
    test_load_extremes();
    test_final_row();
    test_offset_saturation();
    test_backpressure_fill();
    test_drained_pause();
    test_random_phases();

    wait_drained();
    repeat (5) @(negedge clk);
    if (error_count == 0) begin
      $display("** servo_keyframe_stepper: PASSED **");
    end else begin
      $display("** servo_keyframe_stepper: FAILED **");
    end
    $finish;
  end

endmodule

>>> servo_keyframe_stepper.f
sv/sks_pkg.sv
sv/sks_cfg_regs.sv
sv/sks_lane.sv
sv/sks_out_reg.sv
sv/servo_keyframe_stepper.sv
sv/sks_checker.sv
dv/tb_servo_keyframe_stepper.sv
